// File: hdl/auto_white_balance_gain_loop_assert.svh
// Assertion macros for the white balance gain loop.
`ifndef AUTO_WHITE_BALANCE_GAIN_LOOP_ASSERT_SVH
`define AUTO_WHITE_BALANCE_GAIN_LOOP_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, quiet in reset.
`define AWB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, quiet in reset.
`define AWB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/awb_pkg.sv
// Types, constants and microcode ROM of the white balance gain loop.
package awb_pkg;

  localparam int CNT_W     = 22;
  localparam int SUM_W     = 32;
  localparam int GAIN_W    = 16;
  localparam int ACC_W     = 20;
  localparam int FRM_W     = 5;
  localparam int NUM_W     = 42;
  localparam int DEN_W     = 33;
  localparam int STEP_W    = 4;
  localparam int UPC_W     = 5;

  localparam logic [GAIN_W-1:0] UNITY_GAIN   = GAIN_W'(256);
  localparam logic [FRM_W-1:0]  FRAMES_RESET = FRM_W'(5);
  localparam logic [FRM_W-1:0]  MAX_FRAMES   = FRM_W'(16);

  typedef enum logic [3:0] {
    OP_NOP,
    OP_WAIT,
    OP_LOAD_R,
    OP_LOAD_B,
    OP_LOAD_AR,
    OP_LOAD_AB,
    OP_PREP,
    OP_DIV,
    OP_ACC_R,
    OP_ACC_B,
    OP_MIX_R,
    OP_MIX_B,
    OP_EMIT
  } op_e;

  typedef enum logic [2:0] {
    JC_NEXT,
    JC_GOTO,
    JC_NO_ITEM,
    JC_DIV_BUSY,
    JC_BELOW,
    JC_OUT_BUSY
  } cond_e;

  typedef struct packed {
    op_e              op;
    cond_e            cond;
    logic [UPC_W-1:0] target;
  } uctrl_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic step;
  } div_ctrl_t;

  // microcode addresses that are jumped to
  localparam logic [UPC_W-1:0] A_WAIT   = UPC_W'(0);
  localparam logic [UPC_W-1:0] A_LOAD_R = UPC_W'(1);
  localparam logic [UPC_W-1:0] A_DIV_R  = UPC_W'(3);
  localparam logic [UPC_W-1:0] A_DIV_B  = UPC_W'(7);
  localparam logic [UPC_W-1:0] A_DIV_AR = UPC_W'(12);
  localparam logic [UPC_W-1:0] A_DIV_AB = UPC_W'(16);
  localparam logic [UPC_W-1:0] A_EMIT   = UPC_W'(18);

  function automatic uctrl_t uw(op_e o, cond_e c, logic [UPC_W-1:0] t);
    uctrl_t w;
    w.op     = o;
    w.cond   = c;
    w.target = t;
    return w;
  endfunction

  function automatic uctrl_t ucode(logic [UPC_W-1:0] a);
    uctrl_t w;
    unique case (a)
      5'd0:    w = uw(OP_WAIT,    JC_NO_ITEM,  A_WAIT);
      5'd1:    w = uw(OP_LOAD_R,  JC_NEXT,     A_WAIT);
      5'd2:    w = uw(OP_PREP,    JC_NEXT,     A_WAIT);
      5'd3:    w = uw(OP_DIV,     JC_DIV_BUSY, A_DIV_R);
      5'd4:    w = uw(OP_ACC_R,   JC_NEXT,     A_WAIT);
      5'd5:    w = uw(OP_LOAD_B,  JC_NEXT,     A_WAIT);
      5'd6:    w = uw(OP_PREP,    JC_NEXT,     A_WAIT);
      5'd7:    w = uw(OP_DIV,     JC_DIV_BUSY, A_DIV_B);
      5'd8:    w = uw(OP_ACC_B,   JC_NEXT,     A_WAIT);
      5'd9:    w = uw(OP_NOP,     JC_BELOW,    A_WAIT);
      5'd10:   w = uw(OP_LOAD_AR, JC_NEXT,     A_WAIT);
      5'd11:   w = uw(OP_PREP,    JC_NEXT,     A_WAIT);
      5'd12:   w = uw(OP_DIV,     JC_DIV_BUSY, A_DIV_AR);
      5'd13:   w = uw(OP_MIX_R,   JC_NEXT,     A_WAIT);
      5'd14:   w = uw(OP_LOAD_AB, JC_NEXT,     A_WAIT);
      5'd15:   w = uw(OP_PREP,    JC_NEXT,     A_WAIT);
      5'd16:   w = uw(OP_DIV,     JC_DIV_BUSY, A_DIV_AB);
      5'd17:   w = uw(OP_MIX_B,   JC_NEXT,     A_WAIT);
      5'd18:   w = uw(OP_EMIT,    JC_OUT_BUSY, A_EMIT);
      default: w = uw(OP_NOP,     JC_GOTO,     A_WAIT);
    endcase
    return w;
  endfunction

endpackage

// File: hdl/awb_if.sv
// Channel interfaces: statistic in, gains out, configuration write.
interface awb_stat_if import awb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CNT_W-1:0]  white_patch_count;
  logic [SUM_W-1:0]  red_sum;
  logic [SUM_W-1:0]  green_sum;
  logic [SUM_W-1:0]  blue_sum;

  modport source (output valid, white_patch_count, red_sum, green_sum, blue_sum,
                  input ready);
  modport sink   (input valid, white_patch_count, red_sum, green_sum, blue_sum,
                  output ready);
endinterface

interface awb_gain_if import awb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [GAIN_W-1:0] red_gain;
  logic [GAIN_W-1:0] blue_gain;

  modport source (output valid, red_gain, blue_gain, input ready);
  modport sink   (input valid, red_gain, blue_gain, output ready);
endinterface

interface awb_cfg_if import awb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [FRM_W-1:0] frames_per_update;

  modport source (output valid, frames_per_update, input ready);
  modport sink   (input valid, frames_per_update, output ready);
endinterface

// File: hdl/awb_div.sv
// Restoring divider, one quotient bit per step, 16-bit saturating quotient.
module awb_div import awb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  div_ctrl_t         ctrl_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  output logic [GAIN_W-1:0] quo_o,
  output logic              sat_o,
  output logic              busy_o
);

  logic [NUM_W-1:0]  num_q;
  logic [DEN_W-1:0]  den_q;
  logic [DEN_W-1:0]  rem_q;
  logic [GAIN_W-1:0] quo_q;
  logic              sat_q;
  logic [STEP_W-1:0] step_q;

  logic [GAIN_W-1:0] num_lo;
  logic [DEN_W:0]    trial;
  logic              fits;

  assign num_lo = num_q[GAIN_W-1:0];
  assign trial  = {rem_q, num_lo[step_q]};
  assign fits   = trial >= {1'b0, den_q};

  // quotient >= 2^16 exactly when the top part of the dividend reaches the divisor
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      sat_q  <= 1'b0;
    end else if (ctrl_i.prep) begin
      step_q <= '1;
      sat_q  <= {7'b0, num_q[NUM_W-1:GAIN_W]} >= den_q;
    end else if (ctrl_i.step) begin
      step_q <= step_q - STEP_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      num_q <= num_i;
      den_q <= den_i;
    end
    if (ctrl_i.prep) begin
      rem_q <= {7'b0, num_q[NUM_W-1:GAIN_W]};
    end else if (ctrl_i.step) begin
      rem_q <= fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
      quo_q <= {quo_q[GAIN_W-2:0], fits};
    end
  end

  assign quo_o  = sat_q ? '1 : quo_q;
  assign sat_o  = sat_q;
  assign busy_o = step_q != '0;

endmodule

// File: hdl/auto_white_balance_gain_loop.sv
// Gray-world white balance gain loop: microcoded sequencer around a shared divider.
//
//  channel  dir  handshake      word
//  stat_i   in   valid/ready    white_patch_count, red_sum, green_sum, blue_sum
//  gain_o   out  valid/ready    red_gain, blue_gain
//  cfg_i    in   valid/ready    frames_per_update (ready always high)
//
// A rejected statistic (zero count, red or blue sum) is taken and dropped in the wait step.
// A valid statistic without an update takes two passes of the 16-step
// shared restoring divider plus 8 control steps.
// An update adds two averaging passes of the divider and the emit step,
// which waits while the output register has not drained.
// Reset puts gains at unity, clears the averages and sets frames_per_update to 5.
// A stalled output holds the sequencer at the emit step only.

`include "auto_white_balance_gain_loop_assert.svh"

module auto_white_balance_gain_loop import awb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  awb_stat_if.sink   stat_i,
  awb_gain_if.source gain_o,
  awb_cfg_if.sink    cfg_i
);

  // sequencer
  logic [UPC_W-1:0]  upc_q, upc_d;
  uctrl_t            uw_c;
  logic              jump;

  // configuration and loop state
  logic [FRM_W-1:0]  frames_q;
  logic [FRM_W-1:0]  limit;
  logic [GAIN_W-1:0] cur_r_q, cur_b_q;
  logic [ACC_W-1:0]  acc_r_q, acc_b_q;
  logic [FRM_W-1:0]  cnt_q;

  // latched sums of the statistic in flight
  logic [SUM_W-1:0]  rs_q, gs_q, bs_q;

  // output register
  logic              out_valid_q;
  logic [GAIN_W-1:0] out_r_q, out_b_q;

  // divider
  div_ctrl_t         div_ctrl;
  logic [NUM_W-1:0]  div_num;
  logic [DEN_W-1:0]  div_den;
  logic [GAIN_W-1:0] div_quo;
  logic              div_sat;
  logic              div_busy;

  logic              item_ok;
  logic              emit_go;
  logic [GAIN_W:0]   mix_r, mix_b;

  assign uw_c = ucode(upc_q);

  assign item_ok = (stat_i.white_patch_count != '0) && (stat_i.red_sum != '0)
                   && (stat_i.blue_sum != '0);

  // setting of 0 behaves as 1, above the maximum as the maximum
  always_comb begin
    priority if (frames_q == '0) limit = FRM_W'(1);
    else if (frames_q > MAX_FRAMES) limit = MAX_FRAMES;
    else limit = frames_q;
  end

  assign emit_go = !out_valid_q || gain_o.ready;

  always_comb begin
    unique case (uw_c.cond)
      JC_NEXT:     jump = 1'b0;
      JC_GOTO:     jump = 1'b1;
      JC_NO_ITEM:  jump = !stat_i.valid || !item_ok;
      JC_DIV_BUSY: jump = div_busy;
      JC_BELOW:    jump = cnt_q < limit;
      JC_OUT_BUSY: jump = !emit_go;
      default:     jump = 1'b1;
    endcase
    upc_d = jump ? uw_c.target : upc_q + UPC_W'(1);
  end

  // divider operands: per-frame ratio is (512*G + D) / (2*D)
  always_comb begin
    div_ctrl.load = 1'b0;
    div_ctrl.prep = uw_c.op == OP_PREP;
    div_ctrl.step = uw_c.op == OP_DIV;
    div_num       = '0;
    div_den       = '0;
    unique case (uw_c.op)
      OP_LOAD_R: begin
        div_ctrl.load = 1'b1;
        div_num = {1'b0, gs_q, 9'b0} + {10'b0, rs_q};
        div_den = {rs_q, 1'b0};
      end
      OP_LOAD_B: begin
        div_ctrl.load = 1'b1;
        div_num = {1'b0, gs_q, 9'b0} + {10'b0, bs_q};
        div_den = {bs_q, 1'b0};
      end
      OP_LOAD_AR: begin
        div_ctrl.load = 1'b1;
        div_num = {{(NUM_W-ACC_W){1'b0}}, acc_r_q};
        div_den = {{(DEN_W-FRM_W){1'b0}}, cnt_q};
      end
      OP_LOAD_AB: begin
        div_ctrl.load = 1'b1;
        div_num = {{(NUM_W-ACC_W){1'b0}}, acc_b_q};
        div_den = {{(DEN_W-FRM_W){1'b0}}, cnt_q};
      end
      default: begin
        div_ctrl.load = 1'b0;
      end
    endcase
  end

  awb_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (div_ctrl),
    .num_i  (div_num),
    .den_i  (div_den),
    .quo_o  (div_quo),
    .sat_o  (div_sat),
    .busy_o (div_busy)
  );

  // halfway step toward the average, rounded up
  assign mix_r = {1'b0, cur_r_q} + {1'b0, div_quo} + (GAIN_W+1)'(1);
  assign mix_b = {1'b0, cur_b_q} + {1'b0, div_quo} + (GAIN_W+1)'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q       <= A_WAIT;
      frames_q    <= FRAMES_RESET;
      cur_r_q     <= UNITY_GAIN;
      cur_b_q     <= UNITY_GAIN;
      acc_r_q     <= '0;
      acc_b_q     <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      upc_q <= upc_d;
      if (cfg_i.valid) begin
        frames_q <= cfg_i.frames_per_update;
      end
      if (gain_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (uw_c.op)
        OP_ACC_R: acc_r_q <= acc_r_q + ACC_W'(div_quo);
        OP_ACC_B: begin
          acc_b_q <= acc_b_q + ACC_W'(div_quo);
          cnt_q   <= cnt_q + FRM_W'(1);
        end
        OP_MIX_R: cur_r_q <= mix_r[GAIN_W:1];
        OP_MIX_B: begin
          cur_b_q <= mix_b[GAIN_W:1];
          acc_r_q <= '0;
          acc_b_q <= '0;
          cnt_q   <= '0;
        end
        OP_EMIT: begin
          if (emit_go) out_valid_q <= 1'b1;
        end
        default: begin
          cnt_q <= cnt_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (stat_i.valid && stat_i.ready) begin
      rs_q <= stat_i.red_sum;
      gs_q <= stat_i.green_sum;
      bs_q <= stat_i.blue_sum;
    end
    if (uw_c.op == OP_EMIT && emit_go) begin
      out_r_q <= cur_r_q;
      out_b_q <= cur_b_q;
    end
  end

  assign stat_i.ready     = uw_c.op == OP_WAIT;
  assign cfg_i.ready      = 1'b1;
  assign gain_o.valid     = out_valid_q;
  assign gain_o.red_gain  = out_r_q;
  assign gain_o.blue_gain = out_b_q;

  // averaging count never runs past the largest window
  `AWB_ASSERT_NOW(a_cnt_range, 1'b1, cnt_q <= MAX_FRAMES, "frame count beyond window")
  // an average of 16-bit gains can never saturate the divider
  `AWB_ASSERT_NOW(a_avg_no_sat, uw_c.op == OP_MIX_R || uw_c.op == OP_MIX_B, !div_sat,
                  "averaging quotient saturated")
  // a new result only ever comes from the emit step
  `AWB_ASSERT_NEXT(a_emit_src, !out_valid_q && !(uw_c.op == OP_EMIT), !out_valid_q,
                   "output raised outside emit")

endmodule
